FILE: src/shift_register_display_driver_assert.svh
//------------------------------------------------------------------------------
// Assertion macros for the shift register display driver
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
//------------------------------------------------------------------------------
`ifndef SHIFT_REGISTER_DISPLAY_DRIVER_ASSERT_SVH
`define SHIFT_REGISTER_DISPLAY_DRIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRDD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srdd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srdd assertion failed");

`endif

FILE: src/srdd_pkg.sv
//------------------------------------------------------------------------------
// srdd_pkg
// Types, constants and segment/bar encoders for the shift register display
// driver.
//------------------------------------------------------------------------------
`default_nettype none

package srdd_pkg;

    // Chain length as built, limited to the range the chain word supports.
    localparam int ChainBits   = 32;
    localparam int ChainWordW  = 32;
    localparam int ChainLen    = (ChainBits < 8) ? 8 : ((ChainBits > 32) ? 32 : ChainBits);
    localparam int PosW        = 5;
    localparam int HalfW       = 16;
    localparam int ApbAddrW    = 3;
    localparam int ApbDataW    = 32;

    localparam logic [HalfW-1:0] HalfPeriodReset = 16'd100;
    localparam logic [0:0]       RegHalfPeriod   = 1'b0;

    typedef enum logic [1:0] {
        OP_DIGIT = 2'd0,
        OP_BAR   = 2'd1,
        OP_SEND  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCLK_HI,
        ST_PUSH,
        ST_SCLK_LO,
        ST_LATCH
    } t_state;

    typedef struct packed {
        logic set_digit;
        logic set_bar;
        logic load_word;
        logic load_timer;
        logic push;
        logic next_bit;
    } t_cmd;

    typedef struct packed {
        logic timer_done;
        logic slot_free;
        logic last_pos;
    } t_status;

    // Active-low seven-segment pattern; digits above nine show a nine.
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'b1100_0000;
            4'd1:    pat = 8'b1111_1001;
            4'd2:    pat = 8'b1010_0100;
            4'd3:    pat = 8'b1011_0000;
            4'd4:    pat = 8'b1001_1001;
            4'd5:    pat = 8'b1001_0010;
            4'd6:    pat = 8'b1000_0010;
            4'd7:    pat = 8'b1111_1000;
            4'd8:    pat = 8'b1000_0000;
            default: pat = 8'b1001_1000;
        endcase
        return pat;
    endfunction

    // Mask of n low ones, all ones from eight upward.
    function automatic logic [7:0] bar_mask(input logic [3:0] len);
        logic [8:0] ones;
        ones = (9'd1 << len[2:0]) - 9'd1;
        return len[3] ? 8'hFF : ones[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/shift_register_display_driver.sv
// Set-digit and set-bar items are accepted in the idle state only and leave the block idle.
// A send produces one result per chain bit; each bit passes through setup, shift clock high,
// push and shift clock low; setup and both shift clock phases are timed by H, the half
// period register, and the push waits while a stalled consumer holds the result slot.
// A send keeps the block busy through every chain bit and the latch phase that follows.
// Synchronous active-low reset clears the display word and sets H to 100.
//------------------------------------------------------------------------------
// shift_register_display_driver
// Top level: APB half period register, controller and datapath.
//------------------------------------------------------------------------------
`default_nettype none

module shift_register_display_driver (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output      logic                             o_ready,
    input  wire logic [1:0]                       i_operation,
    input  wire logic [3:0]                       i_digit_value,
    input  wire logic [3:0]                       i_bar_length,
    input  wire logic [15:0]                      i_extra_bits,
    output      logic                             o_valid,
    input  wire logic                             i_ready,
    output      logic                             o_serial_bit,
    output      logic [4:0]                       o_bit_position,
    output      logic                             o_last_bit,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [srdd_pkg::ApbAddrW-1:0]    paddr,
    input  wire logic [srdd_pkg::ApbDataW-1:0]    pwdata,
    output      logic [srdd_pkg::ApbDataW-1:0]    prdata,
    output      logic                             pready
);

    logic [srdd_pkg::HalfW-1:0] r_half_period;
    logic                       reg_hit;
    srdd_pkg::t_cmd             cmd;
    srdd_pkg::t_status          status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == srdd_pkg::RegHalfPeriod);

    // A written zero is stored as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= srdd_pkg::HalfPeriodReset;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_half_period <= (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {16'd0, r_half_period};
        end
    end

    srdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    srdd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_digit_value  (i_digit_value),
        .i_bar_length   (i_bar_length),
        .i_extra_bits   (i_extra_bits),
        .i_half_period  (r_half_period),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_serial_bit   (o_serial_bit),
        .o_bit_position (o_bit_position),
        .o_last_bit     (o_last_bit)
    );

endmodule

`default_nettype wire

FILE: src/srdd_dp.sv
//------------------------------------------------------------------------------
// srdd_dp
// Datapath: display word, chain word, bit position, phase timer and the
// output register of the result channel.
//------------------------------------------------------------------------------
`default_nettype none

module srdd_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srdd_pkg::t_cmd                i_cmd,
    output      srdd_pkg::t_status             o_status,
    input  wire logic [3:0]                    i_digit_value,
    input  wire logic [3:0]                    i_bar_length,
    input  wire logic [15:0]                   i_extra_bits,
    input  wire logic [srdd_pkg::HalfW-1:0]    i_half_period,
    input  wire logic                          i_ready,
    output      logic                          o_valid,
    output      logic                          o_serial_bit,
    output      logic [srdd_pkg::PosW-1:0]     o_bit_position,
    output      logic                          o_last_bit
);

    logic [15:0]                       r_display_word;
    logic [srdd_pkg::ChainWordW-1:0]   r_chain_word;
    logic [srdd_pkg::PosW-1:0]         r_bit_pos;
    logic [srdd_pkg::HalfW-1:0]        r_timer;
    logic                              r_out_valid;
    logic                              r_out_bit;
    logic [srdd_pkg::PosW-1:0]         r_out_pos;
    logic                              r_out_last;

    always_comb begin
        o_status.timer_done = (r_timer == '0);
        o_status.slot_free  = !r_out_valid || i_ready;
        o_status.last_pos   = (r_bit_pos == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_word <= '0;
        end else if (i_cmd.set_digit) begin
            r_display_word[7:0] <= srdd_pkg::seg_pattern(i_digit_value);
        end else if (i_cmd.set_bar) begin
            r_display_word[15:8] <= srdd_pkg::bar_mask(i_bar_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos <= '0;
        end else if (i_cmd.load_word) begin
            r_bit_pos <= srdd_pkg::PosW'(srdd_pkg::ChainLen - 1);
        end else if (i_cmd.next_bit) begin
            r_bit_pos <= r_bit_pos - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_chain_word <= {i_extra_bits, r_display_word};
        end
    end

    // Counts down the cycles of one phase; zero marks the last cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
        end else if (i_cmd.load_timer) begin
            r_timer <= i_half_period - 1'b1;
        end else if (r_timer != '0) begin
            r_timer <= r_timer - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_bit  <= r_chain_word[r_bit_pos];
            r_out_pos  <= r_bit_pos;
            r_out_last <= (r_bit_pos == '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_serial_bit   = r_out_bit;
    assign o_bit_position = r_out_pos;
    assign o_last_bit     = r_out_last;

`include "shift_register_display_driver_assert.svh"

    `SRDD_ASSERT_SAME(a_last_is_pos_zero, r_out_valid && r_out_last, r_out_pos == '0)
    `SRDD_ASSERT_NEXT(a_push_fills_slot, i_cmd.push, r_out_valid)
    `SRDD_ASSERT_SAME(a_pos_in_chain, 1'b1, r_bit_pos <= srdd_pkg::PosW'(srdd_pkg::ChainLen - 1))

endmodule

`default_nettype wire

FILE: src/srdd_ctrl.sv
//------------------------------------------------------------------------------
// srdd_ctrl
// Controller: sequences setup, shift clock high, result push, shift clock low
// for every chain bit, then the latch phase.
//------------------------------------------------------------------------------
`default_nettype none

module srdd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_operation,
    output      logic               o_ready,
    output      srdd_pkg::t_cmd     o_cmd,
    input  wire srdd_pkg::t_status  i_status
);

    srdd_pkg::t_state r_state;
    srdd_pkg::t_state n_state;
    srdd_pkg::t_op    op;
    logic             accept;

    assign op     = srdd_pkg::t_op'(i_operation);
    assign accept = (r_state == srdd_pkg::ST_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srdd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srdd_pkg::ST_IDLE: begin
                if (accept && op == srdd_pkg::OP_SEND) begin
                    n_state = srdd_pkg::ST_SETUP;
                end
            end
            srdd_pkg::ST_SETUP: begin
                if (i_status.timer_done) begin
                    n_state = srdd_pkg::ST_SCLK_HI;
                end
            end
            srdd_pkg::ST_SCLK_HI: begin
                if (i_status.timer_done) begin
                    n_state = srdd_pkg::ST_PUSH;
                end
            end
            srdd_pkg::ST_PUSH: begin
                if (i_status.slot_free) begin
                    n_state = srdd_pkg::ST_SCLK_LO;
                end
            end
            srdd_pkg::ST_SCLK_LO: begin
                if (i_status.timer_done) begin
                    n_state = i_status.last_pos ? srdd_pkg::ST_LATCH : srdd_pkg::ST_SETUP;
                end
            end
            srdd_pkg::ST_LATCH: begin
                if (i_status.timer_done) begin
                    n_state = srdd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srdd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            srdd_pkg::ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.set_digit  = accept && op == srdd_pkg::OP_DIGIT;
                o_cmd.set_bar    = accept && op == srdd_pkg::OP_BAR;
                o_cmd.load_word  = accept && op == srdd_pkg::OP_SEND;
                o_cmd.load_timer = accept && op == srdd_pkg::OP_SEND;
            end
            srdd_pkg::ST_SETUP: begin
                o_cmd.load_timer = i_status.timer_done;
            end
            srdd_pkg::ST_SCLK_HI: begin
                o_cmd.load_timer = 1'b0;
            end
            srdd_pkg::ST_PUSH: begin
                // The low phase starts once the result has a place to go.
                o_cmd.push       = i_status.slot_free;
                o_cmd.load_timer = i_status.slot_free;
            end
            srdd_pkg::ST_SCLK_LO: begin
                o_cmd.load_timer = i_status.timer_done;
                o_cmd.next_bit   = i_status.timer_done && !i_status.last_pos;
            end
            srdd_pkg::ST_LATCH: begin
                o_cmd.load_timer = 1'b0;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`include "shift_register_display_driver_assert.svh"

    `SRDD_ASSERT_NEXT(a_send_starts_setup, accept && op == srdd_pkg::OP_SEND, r_state == srdd_pkg::ST_SETUP)
    `SRDD_ASSERT_SAME(a_push_needs_slot, o_cmd.push, i_status.slot_free)
    `SRDD_ASSERT_SAME(a_latch_after_low, r_state == srdd_pkg::ST_LATCH, $past(r_state) == srdd_pkg::ST_SCLK_LO || $past(r_state) == srdd_pkg::ST_LATCH)

endmodule

`default_nettype wire

FILE: sim/shift_register_display_driver_test.sv
//------------------------------------------------------------------------------
// shift_register_display_driver_test
// Drives digit, bar and send items into the display driver and checks every
// shifted chain bit against a predictor that keeps its own display word.
// The half period register is set over APB between phases, and both
// handshake sides idle and stall at random.
//------------------------------------------------------------------------------
module shift_register_display_driver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2_000_000;
    localparam logic [srdd_pkg::ApbAddrW-1:0] HalfPeriodAddr =
        srdd_pkg::ApbAddrW'(4 * srdd_pkg::RegHalfPeriod);

    typedef struct packed {
        logic       serial;
        logic [4:0] pos;
        logic       last;
    } t_chain_bit;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [1:0]                    i_operation;
    logic [3:0]                    i_digit_value;
    logic [3:0]                    i_bar_length;
    logic [15:0]                   i_extra_bits;
    logic                          o_valid;
    logic                          i_ready;
    logic                          o_serial_bit;
    logic [4:0]                    o_bit_position;
    logic                          o_last_bit;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [srdd_pkg::ApbAddrW-1:0] paddr;
    logic [srdd_pkg::ApbDataW-1:0] pwdata;
    logic [srdd_pkg::ApbDataW-1:0] prdata;
    logic                          pready;

    // Predictor state and the chain bits still owed by the block.
    logic [15:0] shown_word;
    t_chain_bit  pending_bits[$];
    int          half_eff;
    bit          last_was_send;
    int          mismatch_count;
    bit          idle_en;
    int          hold_left;

    shift_register_display_driver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_digit_value  (i_digit_value),
        .i_bar_length   (i_bar_length),
        .i_extra_bits   (i_extra_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_serial_bit   (o_serial_bit),
        .o_bit_position (o_bit_position),
        .o_last_bit     (o_last_bit),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Updates the display word, or queues the chain bits that a send shifts out.
    function automatic void apply_item(input srdd_pkg::t_op op, input logic [3:0] digit,
                                       input logic [3:0] bar, input logic [15:0] extra);
        logic [7:0]  segs;
        logic [7:0]  mask;
        logic [31:0] chain_word;
        t_chain_bit  cb;
        int          pos;
        case (op)
            srdd_pkg::OP_DIGIT: begin
                case ((digit > 4'd9) ? 4'd9 : digit)
                    4'd0:    segs = 8'hC0;
                    4'd1:    segs = 8'hF9;
                    4'd2:    segs = 8'hA4;
                    4'd3:    segs = 8'hB0;
                    4'd4:    segs = 8'h99;
                    4'd5:    segs = 8'h92;
                    4'd6:    segs = 8'h82;
                    4'd7:    segs = 8'hF8;
                    4'd8:    segs = 8'h80;
                    default: segs = 8'h98;
                endcase
                shown_word[7:0] = segs;
            end
            srdd_pkg::OP_BAR: begin
                mask = (bar >= 4'd8) ? 8'hFF : 8'((9'd1 << bar) - 9'd1);
                shown_word[15:8] = mask;
            end
            srdd_pkg::OP_SEND: begin
                chain_word = {extra, shown_word};
                for (int k = 0; k < srdd_pkg::ChainLen; k++) begin
                    pos = srdd_pkg::ChainLen - 1 - k;
                    cb.serial = chain_word[pos];
                    cb.pos = pos[4:0];
                    cb.last = (k == srdd_pkg::ChainLen - 1);
                    pending_bits.push_back(cb);
                end
            end
            default: ;
        endcase
    endfunction

    // Input items are predicted before results are checked in the same cycle.
    always @(posedge i_clk) begin
        t_chain_bit want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                apply_item(srdd_pkg::t_op'(i_operation), i_digit_value, i_bar_length,
                           i_extra_bits);
            end
            if (o_valid && i_ready) begin
                if (pending_bits.size() == 0) begin
                    $error("unexpected chain bit: serial_bit=%0d bit_position=%0d",
                           o_serial_bit, o_bit_position);
                    mismatch_count++;
                end else begin
                    want = pending_bits.pop_front();
                    if (o_serial_bit !== want.serial) begin
                        $error("serial_bit: expected %0d, got %0d", want.serial, o_serial_bit);
                        mismatch_count++;
                    end
                    if (o_bit_position !== want.pos) begin
                        $error("bit_position: expected %0d, got %0d", want.pos, o_bit_position);
                        mismatch_count++;
                    end
                    if (o_last_bit !== want.last) begin
                        $error("last_bit: expected %0d, got %0d", want.last, o_last_bit);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Consumer side; a hold-off request keeps ready low until its count runs out.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = !idle_en || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input srdd_pkg::t_op op, input logic [3:0] digit,
                             input logic [3:0] bar, input logic [15:0] extra);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 99) < 23) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_operation = op;
        i_digit_value = digit;
        i_bar_length = bar;
        i_extra_bits = extra;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        last_was_send = (op == srdd_pkg::OP_SEND);
    endtask

    // Waits for every owed chain bit, then for the latch phase to finish.
    task automatic drain_results();
        int settle;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_bits.size() != 0) @(posedge i_clk);
        settle = last_was_send ? 2 * (half_eff + 1) + 16 : 16;
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic check_half_period(input logic [15:0] want);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = HalfPeriodAddr;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== want) begin
            $error("half_period_cycles: expected %0d, got %0d", want, prdata[15:0]);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_half_period(input logic [15:0] value);
        drain_results();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = HalfPeriodAddr;
        pwdata = {16'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        half_eff = (value == 16'd0) ? 1 : int'(value);
        if (value != 16'd0) check_half_period(value);
    endtask

    task automatic test_reset_state();
        check_half_period(srdd_pkg::HalfPeriodReset);
        send_item(srdd_pkg::OP_SEND, 4'd0, 4'd0, 16'h0000);
    endtask

    task automatic test_extreme_fields();
        set_half_period(16'd1);
        send_item(srdd_pkg::OP_DIGIT, 4'd0, 4'd15, 16'hFFFF);
        send_item(srdd_pkg::OP_BAR, 4'd15, 4'd0, 16'hFFFF);
        send_item(srdd_pkg::OP_SEND, 4'd0, 4'd0, 16'hFFFF);
        send_item(srdd_pkg::OP_DIGIT, 4'd15, 4'd0, 16'h0000);
        send_item(srdd_pkg::OP_BAR, 4'd0, 4'd15, 16'h0000);
        send_item(srdd_pkg::OP_SEND, 4'd15, 4'd15, 16'h0000);
        send_item(srdd_pkg::OP_DIGIT, 4'd10, 4'd7, 16'h1234);
        send_item(srdd_pkg::OP_BAR, 4'd9, 4'd8, 16'h4321);
        send_item(srdd_pkg::OP_SEND, 4'd3, 4'd3, 16'hA5A5);
        send_item(srdd_pkg::OP_DIGIT, 4'd8, 4'd8, 16'h0001);
        send_item(srdd_pkg::OP_BAR, 4'd7, 4'd7, 16'h8000);
        send_item(srdd_pkg::OP_SEND, 4'd6, 4'd9, 16'h5A5A);
    endtask

    task automatic test_unused_operation();
        send_item(srdd_pkg::OP_NONE, 4'd1, 4'd1, 16'hFFFF);
        send_item(srdd_pkg::OP_SEND, 4'd2, 4'd2, 16'h0F0F);
    endtask

    // A written zero must behave as a written one.
    task automatic test_zero_half_period();
        set_half_period(16'd0);
        send_item(srdd_pkg::OP_SEND, 4'd5, 4'd5, 16'hC3C3);
    endtask

    // No send at the largest half period: it would outlast the watchdog.
    task automatic test_long_half_period();
        set_half_period(16'hFFFF);
        send_item(srdd_pkg::OP_DIGIT, 4'd4, 4'd2, 16'h0000);
        send_item(srdd_pkg::OP_NONE, 4'd0, 4'd0, 16'h0000);
        send_item(srdd_pkg::OP_BAR, 4'd3, 4'd4, 16'h0000);
        set_half_period(16'd2);
        send_item(srdd_pkg::OP_SEND, 4'd0, 4'd0, 16'h7E81);
    endtask

    // The consumer stalls while items keep coming, so the block backs up.
    task automatic test_output_backpressure();
        drain_results();
        @(posedge i_clk);
        hold_left = 400;
        send_item(srdd_pkg::OP_SEND, 4'd1, 4'd1, 16'hBEEF);
        send_item(srdd_pkg::OP_DIGIT, 4'd7, 4'd0, 16'h0000);
        send_item(srdd_pkg::OP_BAR, 4'd0, 4'd5, 16'h0000);
        send_item(srdd_pkg::OP_SEND, 4'd2, 4'd2, 16'h1357);
        send_item(srdd_pkg::OP_SEND, 4'd3, 4'd3, 16'hFACE);
        drain_results();
    endtask

    task automatic run_random(input int count);
        int            done_items;
        srdd_pkg::t_op op;
        while (done_items < count) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 70) begin
                    send_item(srdd_pkg::OP_DIGIT, 4'($urandom), 4'($urandom), 16'($urandom));
                    done_items++;
                end
                if ($urandom_range(0, 99) < 70) begin
                    send_item(srdd_pkg::OP_BAR, 4'($urandom), 4'($urandom), 16'($urandom));
                    done_items++;
                end
                send_item(srdd_pkg::OP_SEND, 4'($urandom), 4'($urandom), 16'($urandom));
                done_items++;
            end else begin
                op = srdd_pkg::t_op'($urandom_range(0, 3));
                send_item(op, 4'($urandom), 4'($urandom), 16'($urandom));
                if (op != srdd_pkg::OP_NONE) done_items++;
            end
        end
    endtask

    // The second phase runs without any idling on either side.
    task automatic test_random_traffic();
        int halves[5];
        halves = '{2, 1, 3, 0, 4};
        for (int p = 0; p < 5; p++) begin
            set_half_period(16'(halves[p]));
            idle_en = (p != 1);
            run_random(60);
        end
        idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operation = srdd_pkg::OP_DIGIT;
        i_digit_value = 4'd0;
        i_bar_length = 4'd0;
        i_extra_bits = 16'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shown_word = 16'd0;
        half_eff = int'(srdd_pkg::HalfPeriodReset);
        last_was_send = 1'b0;
        mismatch_count = 0;
        idle_en = 1'b1;
        hold_left = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_extreme_fields();
        test_unused_operation();
        test_zero_half_period();
        test_long_half_period();
        test_output_backpressure();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: shift_register_display_driver.f
+incdir+src
src/srdd_pkg.sv
src/srdd_dp.sv
src/srdd_ctrl.sv
src/shift_register_display_driver.sv
sim/shift_register_display_driver_test.sv
